FILE: rtl/mrte_pkg.sv
// Shared types and constants of the mesh route table engine.
// Used by every module of the block; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mrte_pkg;

    localparam int ADDR_W = 48;
    localparam int TIME_W = 63;
    localparam int SEQ_W  = 32;
    localparam int HOPS_W = 8;
    localparam int OUT_CNT_W = 6;

    localparam logic [2:0] ACT_ADD        = 3'd0;
    localparam logic [2:0] ACT_PIN        = 3'd1;
    localparam logic [2:0] ACT_UNPIN      = 3'd2;
    localparam logic [2:0] ACT_LOOKUP     = 3'd3;
    localparam logic [2:0] ACT_INVALIDATE = 3'd4;
    localparam logic [2:0] ACT_EXPIRE     = 3'd5;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_OWN     = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_MISSING = 2'd3;

    localparam logic REG_OWN_ADDRESS  = 1'b0;
    localparam logic REG_LIFETIME     = 1'b1;

    typedef struct packed {
        logic [2:0]        action;
        logic [ADDR_W-1:0] dest;
        logic [ADDR_W-1:0] hop;
        logic [HOPS_W-1:0] hops;
        logic [SEQ_W-1:0]  seq;
        logic [TIME_W-1:0] now;
        logic              own_hit;
    } cmd_t;

    typedef struct packed {
        logic [ADDR_W-1:0] dest;
        logic [ADDR_W-1:0] hop;
        logic [HOPS_W-1:0] hops;
        logic [SEQ_W-1:0]  seq;
        logic [TIME_W-1:0] stamp;
        logic              pinned;
    } entry_t;

    typedef struct packed {
        logic [1:0]           status;
        logic [ADDR_W-1:0]    found_hop;
        logic [HOPS_W-1:0]    found_hops;
        logic [SEQ_W-1:0]     found_sequence;
        logic                 found_pinned;
        logic [TIME_W-1:0]    found_last_used;
        logic [OUT_CNT_W-1:0] entries_in_use;
        logic [OUT_CNT_W-1:0] removed;
    } res_t;

endpackage

`default_nettype wire

FILE: rtl/mrte_front.sv
// Front end: accepts actions, flags own-address hits and queues them.
// Depends on mrte_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mrte_front
    import mrte_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    output logic                   full,
    input  wire logic [2:0]        action,
    input  wire logic [ADDR_W-1:0] dest_address,
    input  wire logic [ADDR_W-1:0] hop_address,
    input  wire logic [HOPS_W-1:0] hops,
    input  wire logic [SEQ_W-1:0]  sequence_req,
    input  wire logic [TIME_W-1:0] now_time,
    input  wire logic [ADDR_W-1:0] own_address,
    output logic                   cmd_valid,
    output cmd_t                   cmd,
    input  wire logic              cmd_pop
);

    cmd_t       q_reg [2];
    cmd_t       beat;
    logic       wptr_reg, wptr_next;
    logic       rptr_reg, rptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       do_push;

    always_comb
    begin
        beat.action  = action;
        beat.dest    = dest_address;
        beat.hop     = hop_address;
        beat.hops    = hops;
        beat.seq     = sequence_req;
        beat.now     = now_time;
        beat.own_hit = ((action == ACT_ADD) && (dest_address == own_address)) ||
                       ((action == ACT_PIN) && ((dest_address == own_address) ||
                                                (hop_address == own_address)));
    end

    assign full      = (cnt_reg == 2'd2);
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = q_reg[rptr_reg];
    assign do_push   = push && !full;

    always_comb
    begin
        wptr_next = wptr_reg ^ do_push;
        rptr_next = rptr_reg ^ cmd_pop;
        cnt_next  = cnt_reg + 2'(do_push) - 2'(cmd_pop);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wptr_reg] <= beat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/mrte_engine.sv
// Back end: route table memory and the sequencer that searches and packs it.
// Depends on mrte_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mrte_engine
    import mrte_pkg::*;
#(
    parameter int TABLE_DEPTH = 32
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cmd_valid,
    input  wire cmd_t             cmd,
    output logic                  cmd_pop,
    input  wire logic [SEQ_W-1:0] route_lifetime,
    output logic                  res_valid,
    output res_t                  res,
    input  wire logic             res_ready
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_DECODE = 6'b000010,
        S_SRCH   = 6'b000100,
        S_SWP    = 6'b001000,
        S_ACT    = 6'b010000,
        S_REPLY  = 6'b100000
    } state_t;

    entry_t entry_mem [TABLE_DEPTH];
    entry_t rdata_reg;

    state_t           state_reg, state_next;
    cmd_t             cmd_reg, cmd_next;
    res_t             res_reg, res_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] chk_idx_reg, chk_idx_next;
    logic [CNT_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic             found_reg, found_next;

    logic             rd_en, wr_en;
    logic [IDX_W-1:0] raddr, waddr;
    entry_t           wdata;

    logic              hit, last, is_full, expired, drop;
    logic [TIME_W-1:0] age;
    logic [CNT_W-1:0]  keep_wr, slot;

    always_comb
    begin
        hit     = (rdata_reg.dest == cmd_reg.dest);
        last    = ((chk_idx_reg + CNT_W'(1)) == cnt_reg);
        is_full = (cnt_reg == CNT_W'(TABLE_DEPTH));
        age     = cmd_reg.now - rdata_reg.stamp;
        expired = (cmd_reg.now > rdata_reg.stamp) &&
                  (age > {{(TIME_W-SEQ_W){1'b0}}, route_lifetime});
        drop    = !rdata_reg.pinned &&
                  ((cmd_reg.action == ACT_EXPIRE) ? expired : (rdata_reg.hop == cmd_reg.hop));
        keep_wr = wr_ptr_reg + CNT_W'(!drop);
        slot    = found_reg ? chk_idx_reg : cnt_reg;
    end

    always_comb
    begin
        state_next   = state_reg;
        cmd_next     = cmd_reg;
        res_next     = res_reg;
        cnt_next     = cnt_reg;
        rd_ptr_next  = rd_ptr_reg;
        chk_idx_next = chk_idx_reg;
        wr_ptr_next  = wr_ptr_reg;
        found_next   = found_reg;
        cmd_pop      = 1'b0;
        rd_en        = 1'b0;
        raddr        = rd_ptr_reg[IDX_W-1:0];
        wr_en        = 1'b0;
        waddr        = slot[IDX_W-1:0];
        wdata        = rdata_reg;
        res_valid    = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop    = 1'b1;
                    cmd_next   = cmd;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                res_next                = '0;
                res_next.status         = ST_OK;
                res_next.entries_in_use = OUT_CNT_W'(cnt_reg);
                unique case (cmd_reg.action) inside
                    ACT_ADD, ACT_PIN, ACT_UNPIN, ACT_LOOKUP:
                    begin
                        if (cmd_reg.own_hit)
                        begin
                            res_next.status = ST_OWN;
                            state_next      = S_REPLY;
                        end
                        else if (cnt_reg == '0)
                        begin
                            found_next = 1'b0;
                            state_next = S_ACT;
                        end
                        else
                        begin
                            rd_en        = 1'b1;
                            raddr        = '0;
                            rd_ptr_next  = CNT_W'(1);
                            chk_idx_next = '0;
                            state_next   = S_SRCH;
                        end
                    end
                    ACT_INVALIDATE, ACT_EXPIRE:
                    begin
                        if (cnt_reg == '0)
                        begin
                            state_next = S_REPLY;
                        end
                        else
                        begin
                            rd_en        = 1'b1;
                            raddr        = '0;
                            rd_ptr_next  = CNT_W'(1);
                            chk_idx_next = '0;
                            wr_ptr_next  = '0;
                            state_next   = S_SWP;
                        end
                    end
                    default:
                    begin
                        state_next = S_REPLY;
                    end
                endcase
            end
            S_SRCH:
            begin
                if (hit)
                begin
                    found_next = 1'b1;
                    state_next = S_ACT;
                end
                else if (last)
                begin
                    found_next = 1'b0;
                    state_next = S_ACT;
                end
                else
                begin
                    rd_en        = 1'b1;
                    chk_idx_next = rd_ptr_reg;
                    rd_ptr_next  = rd_ptr_reg + CNT_W'(1);
                end
            end
            S_SWP:
            begin
                if (!drop && (wr_ptr_reg != chk_idx_reg))
                begin
                    wr_en = 1'b1;
                    waddr = wr_ptr_reg[IDX_W-1:0];
                end
                wr_ptr_next = keep_wr;
                if (last)
                begin
                    cnt_next                = keep_wr;
                    res_next.entries_in_use = OUT_CNT_W'(keep_wr);
                    res_next.removed        = OUT_CNT_W'(cnt_reg - keep_wr);
                    state_next              = S_REPLY;
                end
                else
                begin
                    rd_en        = 1'b1;
                    chk_idx_next = rd_ptr_reg;
                    rd_ptr_next  = rd_ptr_reg + CNT_W'(1);
                end
            end
            S_ACT:
            begin
                state_next = S_REPLY;
                unique case (cmd_reg.action) inside
                    ACT_ADD:
                    begin
                        wdata.dest   = cmd_reg.dest;
                        wdata.hop    = cmd_reg.hop;
                        wdata.hops   = cmd_reg.hops;
                        wdata.seq    = cmd_reg.seq;
                        wdata.stamp  = cmd_reg.now;
                        wdata.pinned = 1'b0;
                        if (found_reg)
                        begin
                            wr_en = !rdata_reg.pinned;
                        end
                        else if (is_full)
                        begin
                            res_next.status = ST_FULL;
                        end
                        else
                        begin
                            wr_en                   = 1'b1;
                            cnt_next                = cnt_reg + CNT_W'(1);
                            res_next.entries_in_use = OUT_CNT_W'(cnt_reg + CNT_W'(1));
                        end
                    end
                    ACT_PIN:
                    begin
                        wdata.dest   = cmd_reg.dest;
                        wdata.hop    = cmd_reg.hop;
                        wdata.hops   = HOPS_W'(1);
                        wdata.seq    = found_reg ? rdata_reg.seq : '0;
                        wdata.stamp  = cmd_reg.now;
                        wdata.pinned = 1'b1;
                        if (!found_reg && is_full)
                        begin
                            res_next.status = ST_FULL;
                        end
                        else
                        begin
                            wr_en = 1'b1;
                            if (!found_reg)
                            begin
                                cnt_next                = cnt_reg + CNT_W'(1);
                                res_next.entries_in_use = OUT_CNT_W'(cnt_reg + CNT_W'(1));
                            end
                        end
                    end
                    ACT_UNPIN:
                    begin
                        wdata.pinned = 1'b0;
                        if (found_reg)
                        begin
                            wr_en = 1'b1;
                        end
                        else
                        begin
                            res_next.status = ST_MISSING;
                        end
                    end
                    ACT_LOOKUP:
                    begin
                        if (found_reg)
                        begin
                            res_next.found_hop       = rdata_reg.hop;
                            res_next.found_hops      = rdata_reg.hops;
                            res_next.found_sequence  = rdata_reg.seq;
                            res_next.found_pinned    = rdata_reg.pinned;
                            res_next.found_last_used = rdata_reg.stamp;
                        end
                        else
                        begin
                            res_next.status = ST_MISSING;
                        end
                    end
                    default:
                    begin
                        res_next.status = ST_OK;
                    end
                endcase
            end
            S_REPLY:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign res = res_reg;

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rdata_reg <= entry_mem[raddr];
        end
        if (wr_en)
        begin
            entry_mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        res_reg     <= res_next;
        rd_ptr_reg  <= rd_ptr_next;
        chk_idx_reg <= chk_idx_next;
        wr_ptr_reg  <= wr_ptr_next;
        found_reg   <= found_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/mrte_res_q.sv
// Result queue: holds up to two finished result beats for the consumer.
// Depends on mrte_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mrte_res_q
    import mrte_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    input  wire res_t in_res,
    output logic      in_ready,
    output logic      empty,
    output res_t      out_res,
    input  wire logic pop
);

    res_t       q_reg [2];
    logic       wptr_reg, wptr_next;
    logic       rptr_reg, rptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       do_push, do_pop;

    assign in_ready = (cnt_reg != 2'd2);
    assign empty    = (cnt_reg == 2'd0);
    assign out_res  = q_reg[rptr_reg];
    assign do_push  = in_valid && in_ready;
    assign do_pop   = pop && !empty;

    always_comb
    begin
        wptr_next = wptr_reg ^ do_push;
        rptr_next = rptr_reg ^ do_pop;
        cnt_next  = cnt_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wptr_reg] <= in_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/mesh_route_table_engine_unit.sv
// Mesh route table engine: add, pin, unpin and lookup search the table and
// invalidate and expire sweep every route held, one slot a cycle; an add or pin
// that hits own_address is rejected without a search. Two action beats and two
// result beats are buffered. Reset clears the route count, queues and
// sequencer, and sets own_address 0, lifetime 30000000.
`timescale 1ns / 1ps
`default_nettype none

module mesh_route_table_engine_unit
    import mrte_pkg::*;
#(
    parameter int TABLE_DEPTH = 32
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [3:0]           paddr,
    input  wire logic [63:0]          pwdata,
    output logic [63:0]               prdata,
    output logic                      pready,
    input  wire logic                 push,
    output logic                      full,
    input  wire logic [2:0]           action,
    input  wire logic [ADDR_W-1:0]    dest_address,
    input  wire logic [ADDR_W-1:0]    hop_address,
    input  wire logic [HOPS_W-1:0]    hops,
    input  wire logic [SEQ_W-1:0]     sequence_req,
    input  wire logic [TIME_W-1:0]    now_time,
    output logic                      empty,
    input  wire logic                 pop,
    output logic [1:0]                status,
    output logic [ADDR_W-1:0]         found_hop,
    output logic [HOPS_W-1:0]         found_hops,
    output logic [SEQ_W-1:0]          found_sequence,
    output logic                      found_pinned,
    output logic [TIME_W-1:0]         found_last_used,
    output logic [OUT_CNT_W-1:0]      entries_in_use,
    output logic [OUT_CNT_W-1:0]      removed
);

    logic [ADDR_W-1:0] own_reg;
    logic [SEQ_W-1:0]  lifetime_reg;
    logic              cfg_wr;

    logic cmd_valid, cmd_pop;
    cmd_t cmd;
    logic res_valid, res_ready;
    res_t eng_res, out_res;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        if (paddr[3] == REG_LIFETIME)
        begin
            prdata = {32'b0, lifetime_reg};
        end
        else
        begin
            prdata = {16'b0, own_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_reg      <= '0;
            lifetime_reg <= SEQ_W'(30000000);
        end
        else if (cfg_wr)
        begin
            if (paddr[3] == REG_OWN_ADDRESS)
            begin
                own_reg <= pwdata[ADDR_W-1:0];
            end
            else
            begin
                lifetime_reg <= pwdata[SEQ_W-1:0];
            end
        end
    end

    mrte_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .action       (action),
        .dest_address (dest_address),
        .hop_address  (hop_address),
        .hops         (hops),
        .sequence_req (sequence_req),
        .now_time     (now_time),
        .own_address  (own_reg),
        .cmd_valid    (cmd_valid),
        .cmd          (cmd),
        .cmd_pop      (cmd_pop)
    );

    mrte_engine #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_engine (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd_valid      (cmd_valid),
        .cmd            (cmd),
        .cmd_pop        (cmd_pop),
        .route_lifetime (lifetime_reg),
        .res_valid      (res_valid),
        .res            (eng_res),
        .res_ready      (res_ready)
    );

    mrte_res_q u_res_q (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (res_valid),
        .in_res   (eng_res),
        .in_ready (res_ready),
        .empty    (empty),
        .out_res  (out_res),
        .pop      (pop)
    );

    assign status          = out_res.status;
    assign found_hop       = out_res.found_hop;
    assign found_hops      = out_res.found_hops;
    assign found_sequence  = out_res.found_sequence;
    assign found_pinned    = out_res.found_pinned;
    assign found_last_used = out_res.found_last_used;
    assign entries_in_use  = out_res.entries_in_use;
    assign removed         = out_res.removed;

`ifndef SYNTHESIS
    a_fail_no_found: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (status != ST_OK)) |-> (!found_pinned && (found_hop == '0)))
        else $error("failed action reports a found route");

    a_removed_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (removed != '0)) |-> (status == ST_OK))
        else $error("removal reported with a failing status");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (32'(entries_in_use) <= TABLE_DEPTH))
        else $error("route count beyond table depth");
`endif

endmodule

`default_nettype wire

FILE: test/mesh_route_table_engine_unit_checker.sv
// Checker for the mesh route table engine: watches the action and result
// queues, predicts each result from its own route table and compares.
// Depends on mrte_pkg; configuration is mirrored from the APB writes.
`timescale 1ns / 1ps

module mesh_route_table_engine_unit_checker
    import mrte_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic                 pready,
    input  wire logic [3:0]           paddr,
    input  wire logic [63:0]          pwdata,
    input  wire logic                 push,
    input  wire logic                 full,
    input  wire logic [2:0]           action,
    input  wire logic [ADDR_W-1:0]    dest_address,
    input  wire logic [ADDR_W-1:0]    hop_address,
    input  wire logic [HOPS_W-1:0]    hops,
    input  wire logic [SEQ_W-1:0]     sequence_req,
    input  wire logic [TIME_W-1:0]    now_time,
    input  wire logic                 empty,
    input  wire logic                 pop,
    input  wire logic [1:0]           status,
    input  wire logic [ADDR_W-1:0]    found_hop,
    input  wire logic [HOPS_W-1:0]    found_hops,
    input  wire logic [SEQ_W-1:0]     found_sequence,
    input  wire logic                 found_pinned,
    input  wire logic [TIME_W-1:0]    found_last_used,
    input  wire logic [OUT_CNT_W-1:0] entries_in_use,
    input  wire logic [OUT_CNT_W-1:0] removed,
    output int                        fail_count,
    output int                        pending_count,
    output int                        result_count
);

    localparam int DEPTH = 32;

    logic [ADDR_W-1:0] own_addr;
    logic [SEQ_W-1:0]  lifetime;
    entry_t            routes[DEPTH];
    int                route_total;
    res_t              expected_results[$];

    function automatic int route_slot_of(input logic [ADDR_W-1:0] dst);
        for (int i = 0; i < route_total; i++)
            if (routes[i].dest == dst)
                return i;
        return -1;
    endfunction

    function automatic int sweep_routes(input bit by_age, input logic [ADDR_W-1:0] hop,
                                        input logic [TIME_W-1:0] now);
        int wr;
        int old;
        bit drop;
        wr = 0;
        old = route_total;
        for (int rd = 0; rd < old; rd++)
        begin
            drop = 0;
            if (!routes[rd].pinned)
            begin
                if (!by_age)
                    drop = (routes[rd].hop == hop);
                else
                    drop = (now > routes[rd].stamp) &&
                           ((now - routes[rd].stamp) > {31'd0, lifetime});
            end
            if (!drop)
            begin
                routes[wr] = routes[rd];
                wr++;
            end
        end
        route_total = wr;
        return old - wr;
    endfunction

    function automatic res_t predict_route_action(input logic [2:0] act,
            input logic [ADDR_W-1:0] dst, input logic [ADDR_W-1:0] hop,
            input logic [HOPS_W-1:0] hc, input logic [SEQ_W-1:0] seq,
            input logic [TIME_W-1:0] now);
        res_t r;
        int idx;
        int gone;
        r = '0;
        r.status = ST_OK;
        gone = 0;
        case (act)
            ACT_ADD:
                if (dst == own_addr)
                    r.status = ST_OWN;
                else
                begin
                    idx = route_slot_of(dst);
                    if (idx < 0 && route_total >= DEPTH)
                        r.status = ST_FULL;
                    else
                    begin
                        if (idx < 0)
                        begin
                            idx = route_total++;
                            routes[idx].dest = dst;
                            routes[idx].pinned = 0;
                        end
                        if (!routes[idx].pinned)
                        begin
                            routes[idx].hop = hop;
                            routes[idx].hops = hc;
                            routes[idx].seq = seq;
                            routes[idx].stamp = now;
                        end
                    end
                end
            ACT_PIN:
                if (dst == own_addr || hop == own_addr)
                    r.status = ST_OWN;
                else
                begin
                    idx = route_slot_of(dst);
                    if (idx < 0 && route_total >= DEPTH)
                        r.status = ST_FULL;
                    else
                    begin
                        if (idx < 0)
                        begin
                            idx = route_total++;
                            routes[idx].dest = dst;
                            routes[idx].seq = '0;
                        end
                        routes[idx].pinned = 1;
                        routes[idx].hop = hop;
                        routes[idx].hops = 8'd1;
                        routes[idx].stamp = now;
                    end
                end
            ACT_UNPIN:
            begin
                idx = route_slot_of(dst);
                if (idx < 0)
                    r.status = ST_MISSING;
                else
                    routes[idx].pinned = 0;
            end
            ACT_LOOKUP:
            begin
                idx = route_slot_of(dst);
                if (idx < 0)
                    r.status = ST_MISSING;
                else
                begin
                    r.found_hop = routes[idx].hop;
                    r.found_hops = routes[idx].hops;
                    r.found_sequence = routes[idx].seq;
                    r.found_pinned = routes[idx].pinned;
                    r.found_last_used = routes[idx].stamp;
                end
            end
            ACT_INVALIDATE: gone = sweep_routes(0, hop, now);
            ACT_EXPIRE:     gone = sweep_routes(1, hop, now);
            default: ;
        endcase
        r.entries_in_use = route_total[OUT_CNT_W-1:0];
        r.removed = gone[OUT_CNT_W-1:0];
        return r;
    endfunction

    task automatic report_field(input string name, input logic [63:0] exp_v,
                                input logic [63:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, exp_v, act_v);
            fail_count++;
        end
    endtask

    assign pending_count = expected_results.size();

    always @(posedge clk or negedge rst_n)
    begin
        res_t exp_r;
        if (!rst_n)
        begin
            own_addr <= '0;
            lifetime <= 32'd30000000;
            route_total = 0;
            fail_count = 0;
            result_count = 0;
            expected_results.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[3] == REG_OWN_ADDRESS)
                    own_addr <= pwdata[ADDR_W-1:0];
                else
                    lifetime <= pwdata[SEQ_W-1:0];
            end
            if (push && !full)
                expected_results.push_back(predict_route_action(action, dest_address,
                    hop_address, hops, sequence_req, now_time));
            if (pop && !empty)
            begin
                result_count++;
                if (expected_results.size() == 0)
                begin
                    $display("%0t: result beat with no expectation waiting", $time);
                    fail_count++;
                end
                else
                begin
                    exp_r = expected_results.pop_front();
                    report_field("status", exp_r.status, status);
                    report_field("found_hop", exp_r.found_hop, found_hop);
                    report_field("found_hops", exp_r.found_hops, found_hops);
                    report_field("found_sequence", exp_r.found_sequence, found_sequence);
                    report_field("found_pinned", exp_r.found_pinned, found_pinned);
                    report_field("found_last_used", exp_r.found_last_used, found_last_used);
                    report_field("entries_in_use", exp_r.entries_in_use, entries_in_use);
                    report_field("removed", exp_r.removed, removed);
                end
            end
        end
    end

endmodule

FILE: test/mesh_route_table_engine_unit_test.sv
// Top of the route table engine testbench: clock, reset, APB set-up,
// action stimulus and result popping. Depends on mrte_pkg, the block and
// mesh_route_table_engine_unit_checker, which does the prediction.
`timescale 1ns / 1ps

module mesh_route_table_engine_unit_test;
    import mrte_pkg::*;

    logic clk = 0;
    logic rst_n = 0;
    logic psel = 0, penable = 0, pwrite = 0;
    logic [3:0] paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic pready;
    logic push = 0;
    logic full;
    logic [2:0] action = '0;
    logic [ADDR_W-1:0] dest_address = '0, hop_address = '0;
    logic [HOPS_W-1:0] hops = '0;
    logic [SEQ_W-1:0] sequence_req = '0;
    logic [TIME_W-1:0] now_time = '0;
    logic empty;
    logic pop = 0;
    logic [1:0] status;
    logic [ADDR_W-1:0] found_hop;
    logic [HOPS_W-1:0] found_hops;
    logic [SEQ_W-1:0] found_sequence;
    logic found_pinned;
    logic [TIME_W-1:0] found_last_used;
    logic [OUT_CNT_W-1:0] entries_in_use, removed;
    int fail_count, pending_count, result_count;

    int  pop_idle_pct = 35;
    bit  hold_results = 0;
    logic [ADDR_W-1:0] own_now = '0;
    logic [ADDR_W-1:0] addr_pool[8];
    logic [TIME_W-1:0] clock_us = '0;

    always #2 clk = ~clk;

    mesh_route_table_engine_unit u_dut (.*);

    mesh_route_table_engine_unit_checker u_checker (.*);

    initial
    begin
        #4000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // result side: random pops, or held off entirely on request
    always @(posedge clk)
        pop <= !hold_results && ($urandom_range(99) >= pop_idle_pct);

    task automatic write_reg(input logic [3:0] addr, input logic [63:0] value);
        psel <= 1; pwrite <= 1; paddr <= addr; pwdata <= value; penable <= 0;
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        @(posedge clk);
    endtask

    task automatic send_beat(input logic [2:0] act, input logic [ADDR_W-1:0] dst,
                             input logic [ADDR_W-1:0] hop, input logic [HOPS_W-1:0] hc,
                             input logic [SEQ_W-1:0] seq, input logic [TIME_W-1:0] now,
                             input int idle_pct);
        while ($urandom_range(99) < idle_pct)
        begin
            push <= 0;
            @(posedge clk);
        end
        push <= 1; action <= act; dest_address <= dst; hop_address <= hop;
        hops <= hc; sequence_req <= seq; now_time <= now;
        @(posedge clk);
        while (full)
            @(posedge clk);
    endtask

    task automatic drain_results();
        push <= 0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    function automatic logic [ADDR_W-1:0] pick_addr();
        if ($urandom_range(9) < 8)
            return addr_pool[$urandom_range(7)];
        return ADDR_W'({$urandom, $urandom});
    endfunction

    task automatic random_phase(input int count, input int idle_pct, input bit wide_table);
        logic [2:0] act;
        logic [ADDR_W-1:0] dst;
        for (int n = 0; n < count; n++)
        begin
            clock_us = clock_us + TIME_W'($urandom_range(2000000));
            act = $urandom_range(99) < 40 ? ACT_ADD : 3'($urandom_range(7));
            dst = wide_table ? ADDR_W'({$urandom, $urandom}) : pick_addr();
            if ($urandom_range(49) == 0)
                dst = own_now;
            send_beat(act, dst, $urandom_range(3) == 0 ? own_now : pick_addr(),
                      8'($urandom), $urandom,
                      $urandom_range(19) == 0 ? TIME_W'({$urandom, $urandom}) : clock_us,
                      idle_pct);
        end
    endtask

    initial
    begin
        for (int i = 0; i < 8; i++)
            addr_pool[i] = ADDR_W'({$urandom, $urandom});
        repeat (11) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: reset configuration, extremes and special cases
        send_beat(ACT_ADD, '0, '1, 8'hFF, '1, '1, 0);
        send_beat(ACT_ADD, '1, '0, 8'h00, '0, '0, 0);
        send_beat(ACT_ADD, '1, 48'h5, 8'h7, 32'h9, 63'd10, 0);
        send_beat(ACT_LOOKUP, '1, '0, '0, '0, '0, 0);
        send_beat(ACT_PIN, '1, '0, '0, '0, '0, 0);
        send_beat(ACT_PIN, 48'h12, 48'h34, '0, '0, 63'd100, 0);
        send_beat(ACT_ADD, 48'h12, 48'h99, 8'h3, 32'h3, 63'd200, 0);
        send_beat(ACT_LOOKUP, 48'h12, '0, '0, '0, '0, 0);
        send_beat(ACT_UNPIN, 48'h77, '0, '0, '0, '0, 0);
        send_beat(ACT_LOOKUP, 48'h77, '0, '0, '0, '0, 0);
        send_beat(ACT_PIN, '1, 48'h34, '0, '0, 63'd300, 0);
        send_beat(ACT_INVALIDATE, '0, 48'h34, '0, '0, '0, 0);
        send_beat(ACT_UNPIN, 48'h12, '0, '0, '0, '0, 0);
        send_beat(ACT_INVALIDATE, '0, 48'h34, '0, '0, '0, 0);
        send_beat(ACT_EXPIRE, '0, '0, '0, '0, 63'd5, 0);
        send_beat(ACT_EXPIRE, '0, '0, '0, '0, '1, 0);
        send_beat(3'd6, '1, '1, '1, '1, '1, 0);
        send_beat(3'd7, '0, '0, '0, '0, '0, 0);
        drain_results();

        write_reg(4'h0, 64'h0000_FFFF_FFFF_FFFF);
        write_reg(4'h8, 64'd0);
        own_now = '1;
        send_beat(ACT_ADD, '1, 48'h1, 8'h1, 32'h1, 63'd1, 0);
        send_beat(ACT_PIN, 48'h3, '1, '0, '0, 63'd1, 0);
        // fill the table past its depth, then expire with lifetime zero
        for (int i = 0; i < 34; i++)
            send_beat(i % 2 ? ACT_PIN : ACT_ADD, 48'h100 + i, 48'h200, 8'h2, i, 63'd50, 0);
        send_beat(ACT_EXPIRE, '0, '0, '0, '0, 63'd50, 0);
        send_beat(ACT_EXPIRE, '0, '0, '0, '0, 63'd51, 0);
        drain_results();

        // long result hold-off so the block backs up and stalls its input
        hold_results = 1;
        fork
            random_phase(40, 0, 0);
            begin
                repeat (400) @(posedge clk);
                hold_results = 0;
            end
        join
        drain_results();

        for (int phase = 0; phase < 6; phase++)
        begin
            own_now = phase == 5 ? '0 : ADDR_W'({$urandom, $urandom});
            write_reg(4'h0, {16'd0, own_now});
            write_reg(4'h8, phase == 4 ? 64'hFFFF_FFFF : 64'($urandom_range(3000000)));
            pop_idle_pct = phase == 2 ? 0 : 35;
            random_phase(300, phase == 2 ? 0 : 35, phase == 3);
            drain_results();
        end

        $display("Covered %0d result beats over directed cases, table full, a stalled",
                 result_count);
        $display("result side and six register settings including the extremes.");
        if (fail_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
